// ===== hw/rtl/incremental_pid_speed_feedforward_defines.svh =====
// Assertion macros for the incremental PID speed controller.
// Included by the top level; expects clk and rst_n in scope.
`ifndef INCREMENTAL_PID_SPEED_FEEDFORWARD_DEFINES_SVH
`define INCREMENTAL_PID_SPEED_FEEDFORWARD_DEFINES_SVH

// condition must hold at every edge out of reset
`define IPIDFF_ASSERT_NOW(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define IPIDFF_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define IPIDFF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/ipidff_pkg.sv =====
// Shared types and constants for the incremental PID speed controller.
// No dependencies; used by every module of the block.
`default_nettype none

package ipidff_pkg;

    localparam int SPEED_BITS = 16;
    localparam int FRAC_BITS  = 8;
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_FRAC  = 8;
    localparam int OUT_W      = 32;

    localparam int FILT_W  = SPEED_BITS + FRAC_BITS;  // filtered speed, Q.FRAC
    localparam int ERR_W   = FILT_W + 1;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int TD_W    = SPEED_BITS + 1;          // first target difference
    localparam int D2_W    = SPEED_BITS + 2;          // second target difference
    localparam int MUL_X_W = (DIFF_W > D2_W + FRAC_BITS) ? DIFF_W : D2_W + FRAC_BITS;
    localparam int PROD_W  = MUL_X_W + GAIN_BITS;
    localparam int TERM_W  = PROD_W - GAIN_FRAC;
    localparam int ACC_W   = OUT_W + 6;

    // filter: q = floor((sum + 2) / 5), sum = raw*2^FRAC + 4*filtered
    localparam int SUM_W       = FILT_W + 3;
    localparam int M_W         = SUM_W + 3;
    localparam int RECIP_SHIFT = M_W + 2;
    localparam int QW          = 2 * M_W - RECIP_SHIFT;
    localparam logic [M_W-1:0] FILT_RECIP =
        M_W'(((64'd1 << RECIP_SHIFT) + 64'd4) / 64'd5);
    // bias keeps the dividend positive: 5*2^(SUM_W-1) plus the rounding 2
    localparam logic [M_W-1:0] FILT_BIAS =
        M_W'((64'd5 << (SUM_W - 1)) + 64'd2);
    localparam logic [QW-1:0] FILT_QOFF = QW'(64'd1 << (SUM_W - 1));

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(64'd1 << (GAIN_FRAC - 1));
    localparam logic signed [ACC_W-1:0]  SAT_HI = ACC_W'({1'b0, {(OUT_W - 1){1'b1}}});
    localparam logic signed [ACC_W-1:0]  SAT_LO = -SAT_HI - ACC_W'(1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_GAIN_FF1    = 3'd3,
        REG_GAIN_FF2    = 3'd4,
        REG_USE_INT     = 3'd5,
        REG_USE_FF      = 3'd6,
        REG_USE_SECOND  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [SPEED_BITS-1:0] speed_target;
        logic signed [SPEED_BITS-1:0] speed_measured;
    } tick_t;

    typedef struct packed {
        logic signed [OUT_W-1:0]  drive_out;
        logic signed [FILT_W-1:0] speed_filtered;
    } drive_t;

    typedef struct packed {
        logic signed [GAIN_BITS-1:0] gain_p;
        logic signed [GAIN_BITS-1:0] gain_i;
        logic signed [GAIN_BITS-1:0] gain_d;
        logic signed [GAIN_BITS-1:0] gain_ff1;
        logic signed [GAIN_BITS-1:0] gain_ff2;
        logic                        use_integral;
        logic                        use_feedforward;
        logic                        use_second_order;
    } cfg_t;

    typedef enum logic [2:0] {
        MUL_P,
        MUL_I,
        MUL_D,
        MUL_F2,
        MUL_F1
    } mul_sel_t;

    typedef enum logic [2:0] {
        ADD_NONE,
        ADD_P,
        ADD_D,
        ADD_F2,
        ADD_F1,
        ADD_INT
    } add_sel_t;

    typedef struct packed {
        logic     load;      // take the request payload
        logic     filt_mul;  // filter reciprocal multiply, target differences
        logic     err_upd;   // new filtered value, error, accumulator load
        logic     diff_upd;  // error difference
        logic     mul_en;
        mul_sel_t mul_sel;
        add_sel_t add_sel;
        logic     int_upd;   // integral sum update from the product register
        logic     finish;    // commit state and write the result register
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ipidff_cfg.sv =====
// Configuration register file: gains and mode flags.
// Depends on ipidff_pkg.
`default_nettype none

module ipidff_cfg (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ipidff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [ipidff_pkg::CFG_DATA_W-1:0]  cfg_data,
    output ipidff_pkg::cfg_t                   cfg
);
    import ipidff_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_GAIN_P:     cfg_next.gain_p           = cfg_data;
                REG_GAIN_I:     cfg_next.gain_i           = cfg_data;
                REG_GAIN_D:     cfg_next.gain_d           = cfg_data;
                REG_GAIN_FF1:   cfg_next.gain_ff1         = cfg_data;
                REG_GAIN_FF2:   cfg_next.gain_ff2         = cfg_data;
                REG_USE_INT:    cfg_next.use_integral     = cfg_data[0];
                REG_USE_FF:     cfg_next.use_feedforward  = cfg_data[0];
                REG_USE_SECOND: cfg_next.use_second_order = cfg_data[0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipidff_ctrl.sv =====
// Sequencer: one tick through filter, error and five shared-multiplier steps.
// Depends on ipidff_pkg; drives the datapath by command struct.
`default_nettype none

module ipidff_ctrl (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               tick_valid,
    output logic              tick_stall,
    input  ipidff_pkg::sts_t  sts,
    output ipidff_pkg::cmd_t  cmd
);
    import ipidff_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_FILT = 11'b000_0000_0010,
        S_ERR  = 11'b000_0000_0100,
        S_MP   = 11'b000_0000_1000,
        S_MI   = 11'b000_0001_0000,
        S_MD   = 11'b000_0010_0000,
        S_MF2  = 11'b000_0100_0000,
        S_MF1  = 11'b000_1000_0000,
        S_AF1  = 11'b001_0000_0000,
        S_AINT = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign tick_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.mul_sel  = MUL_P;
        cmd.add_sel  = ADD_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load = tick_valid;
                if (tick_valid)
                    state_next = S_FILT;
            end
            S_FILT:
            begin
                cmd.filt_mul = 1'b1;
                state_next   = S_ERR;
            end
            S_ERR:
            begin
                cmd.err_upd = 1'b1;
                state_next  = S_MP;
            end
            S_MP:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_sel  = MUL_P;
                cmd.diff_upd = 1'b1;
                state_next   = S_MI;
            end
            S_MI:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_I;
                cmd.add_sel = ADD_P;
                state_next  = S_MD;
            end
            S_MD:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_D;
                cmd.int_upd = 1'b1;
                state_next  = S_MF2;
            end
            S_MF2:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_F2;
                cmd.add_sel = ADD_D;
                state_next  = S_MF1;
            end
            S_MF1:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_F1;
                cmd.add_sel = ADD_F2;
                state_next  = S_AF1;
            end
            S_AF1:
            begin
                cmd.add_sel = ADD_F1;
                state_next  = S_AINT;
            end
            S_AINT:
            begin
                cmd.add_sel = ADD_INT;
                state_next  = S_DONE;
            end
            S_DONE:
            begin
                // hold until the result register has room
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/ipidff_dp.sv =====
// Datapath: speed filter, error terms, shared gain multiplier, accumulators
// and result register. Depends on ipidff_pkg; steered by ipidff_ctrl.
`default_nettype none

module ipidff_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  ipidff_pkg::cfg_t    cfg,
    input  ipidff_pkg::cmd_t    cmd,
    output ipidff_pkg::sts_t    sts,
    input  ipidff_pkg::tick_t   tick,
    output ipidff_pkg::drive_t  drive,
    output logic                drive_valid,
    input  wire                 drive_stall
);
    import ipidff_pkg::*;

    // tick state
    logic signed [FILT_W-1:0]     filt_reg;
    logic signed [ERR_W-1:0]      prev_err_reg;
    logic signed [OUT_W-1:0]      int_reg;
    logic signed [OUT_W-1:0]      out_acc_reg;
    logic signed [SPEED_BITS-1:0] prev_tgt_reg;
    logic signed [SPEED_BITS-1:0] pprev_tgt_reg;

    // working registers
    logic signed [SPEED_BITS-1:0] tgt_reg;
    logic signed [SPEED_BITS-1:0] raw_reg;
    logic [2*M_W-1:0]             fprod_reg;
    logic signed [ERR_W-1:0]      err_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [TD_W-1:0]       td_reg;
    logic signed [D2_W-1:0]       d2_reg;
    logic signed [PROD_W-1:0]     prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    drive_t                       drive_reg;
    logic                         drive_valid_reg;
    logic                         drive_valid_next;

    logic signed [SUM_W-1:0]      f_sum;
    logic signed [M_W-1:0]        f_sx;
    logic [M_W-1:0]               f_m;
    logic [QW-1:0]                f_q;
    logic signed [FILT_W-1:0]     filt_q;
    logic signed [ERR_W-1:0]      err_new;
    logic signed [TD_W-1:0]       td_new;
    logic signed [TD_W-1:0]       td_old;
    logic signed [MUL_X_W-1:0]    mul_x;
    logic signed [GAIN_BITS-1:0]  mul_g;
    logic signed [PROD_W-1:0]     prod_rnd;
    logic signed [TERM_W-1:0]     term;
    logic signed [ACC_W-1:0]      addend;
    logic signed [ACC_W-1:0]      int_sum;
    logic signed [OUT_W-1:0]      out_sat;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > SAT_HI)
            r = OUT_W'(SAT_HI);
        else if (v < SAT_LO)
            r = OUT_W'(SAT_LO);
        else
            r = OUT_W'(v);
        return r;
    endfunction

    // filter: divide by five through a reciprocal multiply on a biased dividend
    always_comb
    begin
        f_sum  = (SUM_W'(raw_reg) <<< FRAC_BITS) + (SUM_W'(filt_reg) <<< 2);
        f_sx   = M_W'(f_sum);
        f_m    = $unsigned(f_sx) + FILT_BIAS;
        f_q    = fprod_reg[2*M_W-1:RECIP_SHIFT] - FILT_QOFF;
        filt_q = FILT_W'(f_q);
        err_new = (ERR_W'(tgt_reg) <<< FRAC_BITS) - ERR_W'(filt_q);
        td_new  = TD_W'(tgt_reg) - TD_W'(prev_tgt_reg);
        td_old  = TD_W'(prev_tgt_reg) - TD_W'(pprev_tgt_reg);
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_P:
            begin
                mul_x = MUL_X_W'(err_reg);
                mul_g = cfg.gain_p;
            end
            MUL_I:
            begin
                mul_x = MUL_X_W'(err_reg);
                mul_g = cfg.gain_i;
            end
            MUL_D:
            begin
                mul_x = MUL_X_W'(diff_reg);
                mul_g = cfg.gain_d;
            end
            MUL_F2:
            begin
                mul_x = MUL_X_W'(d2_reg) <<< FRAC_BITS;
                mul_g = cfg.gain_ff2;
            end
            MUL_F1:
            begin
                mul_x = MUL_X_W'(td_reg) <<< FRAC_BITS;
                mul_g = cfg.gain_ff1;
            end
            default:
            begin
                mul_x = '0;
                mul_g = '0;
            end
        endcase
    end

    // round half up to Q.FRAC, then pick this step's addend
    always_comb
    begin
        prod_rnd = prod_reg + ROUND_HALF;
        term     = TERM_W'(prod_rnd >>> GAIN_FRAC);
        int_sum  = ACC_W'(int_reg) + ACC_W'(term);
        case (cmd.add_sel)
            ADD_P:   addend = ACC_W'(term);
            ADD_D:   addend = ACC_W'(term);
            ADD_F2:  addend = (cfg.use_feedforward && cfg.use_second_order) ?
                              ACC_W'(term) : '0;
            ADD_F1:  addend = cfg.use_feedforward ? ACC_W'(term) : '0;
            ADD_INT: addend = cfg.use_integral ? ACC_W'(int_reg) : '0;
            default: addend = '0;
        endcase
        out_sat = sat_out(acc_reg);
    end

    assign sts.out_free = !drive_valid_reg || !drive_stall;

    always_comb
    begin
        drive_valid_next = drive_valid_reg;
        if (cmd.finish)
            drive_valid_next = 1'b1;
        else if (!drive_stall)
            drive_valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tgt_reg <= tick.speed_target;
            raw_reg <= tick.speed_measured;
        end
        if (cmd.filt_mul)
        begin
            fprod_reg <= (2 * M_W)'(f_m) * (2 * M_W)'(FILT_RECIP);
            td_reg    <= td_new;
            d2_reg    <= D2_W'(td_new) - D2_W'(td_old);
        end
        if (cmd.err_upd)
            err_reg <= err_new;
        if (cmd.diff_upd)
            diff_reg <= DIFF_W'(err_reg) - DIFF_W'(prev_err_reg);
        if (cmd.mul_en)
            prod_reg <= PROD_W'(mul_x) * PROD_W'(mul_g);
        if (cmd.err_upd)
            acc_reg <= ACC_W'(out_acc_reg);
        else
            acc_reg <= acc_reg + addend;
        if (cmd.finish)
        begin
            drive_reg.drive_out      <= out_sat;
            drive_reg.speed_filtered <= filt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filt_reg        <= '0;
            prev_err_reg    <= '0;
            int_reg         <= '0;
            out_acc_reg     <= '0;
            prev_tgt_reg    <= '0;
            pprev_tgt_reg   <= '0;
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            drive_valid_reg <= drive_valid_next;
            if (cmd.err_upd)
                filt_reg <= filt_q;
            if (cmd.int_upd && cfg.use_integral)
                int_reg <= sat_out(int_sum);
            if (cmd.finish)
            begin
                out_acc_reg  <= out_sat;
                prev_err_reg <= err_reg;
                if (cfg.use_feedforward)
                    prev_tgt_reg <= tgt_reg;
                if (cfg.use_feedforward && cfg.use_second_order)
                    pprev_tgt_reg <= prev_tgt_reg;
            end
        end
    end

    assign drive       = drive_reg;
    assign drive_valid = drive_valid_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/incremental_pid_speed_feedforward.sv =====
// Incremental PID speed controller with optional target feedforward.
// Each request is one control tick: the measured speed is low-pass filtered
// ((raw + 4*previous)/5, rounded), the error against the target drives P, I
// and D gain terms, optional first- and second-order feedforward act on the
// target differences, and the drive accumulator grows by their sum and
// saturates at 32 bits. The sequencer steps each accepted request through a
// reciprocal multiply for the filter, the error update, then five gain
// products through one shared 26x16 multiplier; a new request is taken only
// once the previous one has finished its last step.
// A new request is taken while the previous result still waits downstream;
// it only waits at its last step if that result has not yet been taken.
// Gains and mode flags must be written on the configuration port while idle; the block does not enforce this.
`default_nettype none

module incremental_pid_speed_feedforward (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                tick_valid,
    output logic                               tick_stall,
    input  ipidff_pkg::tick_t                  tick,
    output logic                               drive_valid,
    input  wire                                drive_stall,
    output ipidff_pkg::drive_t                 drive,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire  [ipidff_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [ipidff_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import ipidff_pkg::*;

    `include "incremental_pid_speed_feedforward_defines.svh"

    cfg_t cfg;
    cmd_t cmd;
    sts_t sts;

    ipidff_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ipidff_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick_valid (tick_valid),
        .tick_stall (tick_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    ipidff_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .sts         (sts),
        .tick        (tick),
        .drive       (drive),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall)
    );

    `IPIDFF_ASSERT_NEXT(a_busy_after_request, tick_valid && !tick_stall, tick_stall, "request accepted but controller not busy")
    `IPIDFF_ASSERT_IMPL(a_result_from_busy, $rose(drive_valid), $past(tick_stall), "result appeared without a request in flight")
    `IPIDFF_ASSERT_NOW(a_finish_needs_room, !(cmd.finish && drive_valid && drive_stall), "result written over one still waiting")

endmodule

`default_nettype wire

// ===== sim/tb_incremental_pid_speed_feedforward.sv =====
// Self-checking testbench for the incremental PID speed controller with feedforward.
// Needs ipidff_pkg and the incremental_pid_speed_feedforward top level; drives requests,
// gains and mode flags, and predicts each drive result in a scoreboard class.
`timescale 1ns / 100ps

module tb_incremental_pid_speed_feedforward;

    import ipidff_pkg::*;

    localparam int HOLD_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int RAND_PHASES    = 14;
    localparam int PHASE_TICKS    = 125;

    class drive_scoreboard;
        int errors;
        drive_t drive_due_q[$];
        logic signed [GAIN_BITS-1:0] kp, ki, kd, kf1, kf2;
        bit en_int, en_ff, en_ff2;
        longint filt, last_err, integ, acc, tgt_1, tgt_2;

        function new();
            errors = 0;
            kp = '0; ki = '0; kd = '0; kf1 = '0; kf2 = '0;
            en_int = 1'b0; en_ff = 1'b0; en_ff2 = 1'b0;
            filt = 0; last_err = 0; integ = 0; acc = 0; tgt_1 = 0; tgt_2 = 0;
        endfunction

        function longint floor_div(longint a, longint b);
            longint q;
            q = a / b;
            if ((a % b) != 0 && a < 0)
                q--;
            return q;
        endfunction

        // Q.FRAC value times Q7.8 gain, rounded half up
        function longint gain_mul(longint x, logic signed [GAIN_BITS-1:0] g);
            longint gl;
            gl = g;
            return (x * gl + (longint'(1) << (GAIN_FRAC - 1))) >>> GAIN_FRAC;
        endfunction

        function longint clamp32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:     kp = data;
                REG_GAIN_I:     ki = data;
                REG_GAIN_D:     kd = data;
                REG_GAIN_FF1:   kf1 = data;
                REG_GAIN_FF2:   kf2 = data;
                REG_USE_INT:    en_int = data[0];
                REG_USE_FF:     en_ff = data[0];
                REG_USE_SECOND: en_ff2 = data[0];
                default: ;
            endcase
        endfunction

        function void note_tick(tick_t t);
            longint tgt, raw, err, step, d2, one;
            drive_t want;
            one = longint'(1) << FRAC_BITS;
            tgt = $signed(t.speed_target);
            raw = $signed(t.speed_measured);
            filt = floor_div(2 * (raw * one + 4 * filt) + 5, 10);
            err = tgt * one - filt;
            step = gain_mul(err, kp) + gain_mul(err - last_err, kd);
            if (en_int)
            begin
                integ = clamp32(integ + gain_mul(err, ki));
                step += integ;
            end
            // second order is ignored while feedforward is off
            if (en_ff)
            begin
                if (en_ff2)
                begin
                    d2 = (tgt - tgt_1) - (tgt_1 - tgt_2);
                    step += gain_mul(d2 * one, kf2);
                    tgt_2 = tgt_1;
                end
                step += gain_mul((tgt - tgt_1) * one, kf1);
                tgt_1 = tgt;
            end
            acc = clamp32(acc + step);
            last_err = err;
            want.drive_out = acc[OUT_W-1:0];
            want.speed_filtered = filt[FILT_W-1:0];
            drive_due_q.push_back(want);
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (drive_due_q.size() == 0)
            begin
                $display("%0t: unexpected result drive_out=%0d speed_filtered=%0d",
                         $time, got.drive_out, got.speed_filtered);
                errors++;
                return;
            end
            want = drive_due_q.pop_front();
            if (got.drive_out !== want.drive_out)
            begin
                $display("%0t: drive_out mismatch expected %0d actual %0d",
                         $time, want.drive_out, got.drive_out);
                errors++;
            end
            if (got.speed_filtered !== want.speed_filtered)
            begin
                $display("%0t: speed_filtered mismatch expected %0d actual %0d",
                         $time, want.speed_filtered, got.speed_filtered);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic tick_valid = 1'b0;
    logic tick_stall;
    tick_t tick = '0;
    logic drive_valid;
    logic drive_stall = 1'b0;
    drive_t drive;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    drive_scoreboard sb = new();
    bit hold_req = 1'b0;
    int track_target = 0;

    incremental_pid_speed_feedforward u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick_valid  (tick_valid),
        .tick_stall  (tick_stall),
        .tick        (tick),
        .drive_valid (drive_valid),
        .drive_stall (drive_stall),
        .drive       (drive),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic tick_t mk_tick(logic [15:0] tgt, logic [15:0] meas);
        tick_t t;
        t.speed_target = tgt;
        t.speed_measured = meas;
        return t;
    endfunction

    function automatic logic [15:0] extreme_speed();
        case ($urandom_range(0, 4))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 2048)) - 1024);
        endcase
    endfunction

    // half the time a slowly drifting target with a noisy measurement, else noise and extremes
    function automatic tick_t pick_tick();
        tick_t t;
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            track_target += int'($urandom_range(0, 400)) - 200;
            if (track_target > 30000)
                track_target = 30000;
            if (track_target < -30000)
                track_target = -30000;
            t.speed_target = track_target[15:0];
            t.speed_measured = 16'(track_target + int'($urandom_range(0, 600)) - 300);
        end
        else if (r < 85)
            t = $urandom;
        else
            t = mk_tick(extreme_speed(), extreme_speed());
        return t;
    endfunction

    task automatic send_tick(tick_t t);
        tick_valid <= 1'b1;
        tick <= t;
        @(posedge clk);
        while (tick_stall)
            @(posedge clk);
        sb.note_tick(t);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [15:0] g_p, logic [15:0] g_i, logic [15:0] g_d,
                             logic [15:0] g_f1, logic [15:0] g_f2, logic [15:0] f_int,
                             logic [15:0] f_ff, logic [15:0] f_two);
        write_reg(REG_GAIN_P, g_p);
        write_reg(REG_GAIN_I, g_i);
        write_reg(REG_GAIN_D, g_d);
        write_reg(REG_GAIN_FF1, g_f1);
        write_reg(REG_GAIN_FF2, g_f2);
        write_reg(REG_USE_INT, f_int);
        write_reg(REG_USE_FF, f_ff);
        write_reg(REG_USE_SECOND, f_two);
        cfg_valid <= 1'b0;
    endtask

    // sender pauses until every result is back, then lets the sequencer settle
    task automatic drain();
        tick_valid <= 1'b0;
        while (sb.drive_due_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_ticks(int n, bit gappy);
        int burst;
        burst = $urandom_range(1, 40);
        for (int i = 0; i < n; i++)
        begin
            if (gappy && burst <= 0)
            begin
                tick_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                burst = $urandom_range(1, 40);
            end
            send_tick(pick_tick());
            burst--;
        end
    endtask

    // receiver: check accepted results and drive stall
    initial
    begin
        int mode, mode_left, hold_left, cyc;
        mode = 0;
        mode_left = 100;
        hold_left = 0;
        cyc = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && drive_valid && !drive_stall)
                sb.check_drive(drive);
            cyc++;
            if (hold_req)
            begin
                drive_stall <= 1'b1;
                hold_left++;
                if (hold_left >= HOLD_CYCLES)
                begin
                    hold_left = 0;
                    hold_req = 1'b0;
                end
            end
            else
            begin
                mode_left--;
                if (mode_left <= 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(50, 300);
                end
                case (mode)
                    0:       drive_stall <= 1'b0;
                    1:       drive_stall <= ($urandom_range(0, 3) == 0);
                    2:       drive_stall <= ($urandom_range(0, 3) != 0);
                    default: drive_stall <= ((cyc % 5) < 2);
                endcase
            end
        end
    end

    // watchdog: ends the run after too long without any handshake
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (tick_valid && !tick_stall) || (drive_valid && !drive_stall)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset gains: filter only, drive stays at zero
        send_tick(mk_tick(16'h7fff, 16'h8000));
        send_tick(mk_tick(16'h8000, 16'h7fff));
        send_tick(mk_tick(16'h0000, 16'h0000));
        send_tick(mk_tick(16'hffff, 16'hffff));
        drain();

        // full positive gains, all modes: integral and drive run into saturation
        configure(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h0001, 16'h0001,
                  16'h0001);
        send_tick(mk_tick(16'h7fff, 16'h8000));
        send_tick(mk_tick(16'h8000, 16'h7fff));
        send_tick(mk_tick(16'h7fff, 16'h8000));
        send_tick(mk_tick(16'h8000, 16'h7fff));
        send_tick(mk_tick(16'h7fff, 16'h7fff));
        send_tick(mk_tick(16'h0000, 16'h0000));
        drain();

        // most negative gains; second order requested without feedforward,
        // flag data with only upper bits set reads as off
        configure(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hffff, 16'hfffe,
                  16'h0001);
        send_tick(mk_tick(16'h8000, 16'h7fff));
        send_tick(mk_tick(16'h7fff, 16'h8000));
        send_tick(mk_tick(16'h8000, 16'h8000));
        send_tick(mk_tick(16'h0001, 16'hffff));
        send_tick(mk_tick(16'h7fff, 16'h8000));
        drain();

        // integral off, first-order feedforward only, realistic gains
        configure(16'h0100, 16'h0010, 16'h0080, 16'h0200, 16'h0040, 16'h0000, 16'h0001,
                  16'h0000);
        send_tick(mk_tick(16'd1000, 16'd0));
        send_tick(mk_tick(16'd1200, 16'd300));
        send_tick(mk_tick(16'd1500, 16'd700));
        send_tick(mk_tick(16'd1500, 16'd1100));
        send_tick(mk_tick(16'd1400, 16'd1450));
        drain();

        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            configure(pick_gain(), pick_gain(), pick_gain(), pick_gain(), pick_gain(),
                      16'($urandom), 16'($urandom), 16'($urandom));
            // long downstream hold-off while requests keep coming
            if (ph == 3)
                hold_req = 1'b1;
            run_ticks(PHASE_TICKS, (ph % 3) != 0);
            drain();
        end

        if (sb.errors == 0 && sb.drive_due_q.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
